/* rtl/tpd_pkg.sv */
package tpd_pkg;

    localparam int ACTION_W  = 2;
    localparam int CHAN_W    = 3;
    localparam int LEVEL_W   = 7;
    localparam int STEP_W    = 10;
    localparam int PERIOD_W  = 10;
    localparam int EXTRA_W   = 4;
    localparam int MASK_W    = 5;
    localparam int COUNT_W   = 18;
    localparam int PROD_W    = 17;
    localparam int DIVCNT_W  = 5;
    localparam int UPC_W     = 4;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 8;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 7'd100;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 10'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd30;
    localparam logic [EXTRA_W-1:0]  EXTRA_RESET  = 4'd2;

    typedef enum logic [1:0] {
        REG_STEP   = 2'd0,
        REG_PERIOD = 2'd1,
        REG_EXTRA  = 2'd2,
        REG_NONE   = 2'd3
    } reg_idx_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_ZCROSS  = 2'd1,
        ACT_ENABLE  = 2'd2,
        ACT_DISABLE = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        OP_NOP     = 4'd0,
        OP_TICK    = 4'd1,
        OP_ENABLE  = 4'd2,
        OP_DISABLE = 4'd3,
        OP_CH_CLR  = 4'd4,
        OP_MUL     = 4'd5,
        OP_DIV     = 4'd6,
        OP_WRITE   = 4'd7,
        OP_CH_INC  = 4'd8,
        OP_EMIT    = 4'd9
    } uop_t;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_JUMP     = 3'd1,
        C_DISPATCH = 3'd2,
        C_ZERO_EN  = 3'd3,
        C_SKIP     = 3'd4,
        C_DIV_LOOP = 3'd5,
        C_CH_LOOP  = 3'd6,
        C_WAIT_OUT = 3'd7
    } ucond_t;

    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_FETCH   = 4'd0;
    localparam upc_t UPC_TICK    = 4'd1;
    localparam upc_t UPC_ENABLE  = 4'd2;
    localparam upc_t UPC_DISABLE = 4'd3;
    localparam upc_t UPC_ZCROSS  = 4'd4;
    localparam upc_t UPC_MUL     = 4'd5;
    localparam upc_t UPC_DIV     = 4'd6;
    localparam upc_t UPC_WRITE   = 4'd7;
    localparam upc_t UPC_CH_INC  = 4'd8;
    localparam upc_t UPC_EMIT    = 4'd9;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    function automatic uword_t ucode(input upc_t pc);
        uword_t w;
        unique case (pc)
            UPC_FETCH:   w = '{OP_NOP,     C_DISPATCH, UPC_FETCH};
            UPC_TICK:    w = '{OP_TICK,    C_JUMP,     UPC_EMIT};
            UPC_ENABLE:  w = '{OP_ENABLE,  C_JUMP,     UPC_EMIT};
            UPC_DISABLE: w = '{OP_DISABLE, C_JUMP,     UPC_EMIT};
            UPC_ZCROSS:  w = '{OP_CH_CLR,  C_ZERO_EN,  UPC_EMIT};
            UPC_MUL:     w = '{OP_MUL,     C_SKIP,     UPC_CH_INC};
            UPC_DIV:     w = '{OP_DIV,     C_DIV_LOOP, UPC_DIV};
            UPC_WRITE:   w = '{OP_WRITE,   C_NEXT,     UPC_CH_INC};
            UPC_CH_INC:  w = '{OP_CH_INC,  C_CH_LOOP,  UPC_MUL};
            UPC_EMIT:    w = '{OP_EMIT,    C_WAIT_OUT, UPC_FETCH};
            default:     w = '{OP_NOP,     C_JUMP,     UPC_FETCH};
        endcase
        return w;
    endfunction

endpackage

/* rtl/tpd_div.sv */
module tpd_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tpd_pkg::div_ctrl_t               ctrl,
    input  logic [tpd_pkg::PROD_W-1:0]       dividend,
    input  logic [tpd_pkg::PERIOD_W-1:0]     divisor,
    output logic [tpd_pkg::PROD_W-1:0]       quotient,
    output logic                             last
);
    import tpd_pkg::*;

    logic [PERIOD_W-1:0] rem_reg,  rem_next;
    logic [PROD_W-1:0]   quot_reg, quot_next;
    logic [DIVCNT_W-1:0] cnt_reg,  cnt_next;
    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic                ge;

    assign trial = {rem_reg, quot_reg[PROD_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        if (ctrl.load)
        begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = '0;
        end
        else if (ctrl.step)
        begin
            rem_next  = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
            quot_next = {quot_reg[PROD_W-2:0], ge};
            cnt_next  = cnt_reg + DIVCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;
    assign last     = cnt_reg == DIVCNT_W'(PROD_W - 1);

endmodule

/* rtl/triac_phase_dimmer.sv */
// Multi-channel triac phase-angle dimmer.
// Input stream (s_tvalid/s_tready/s_tdata) carries one event per transaction:
// tick, zero crossing, enable of a channel at a level, or disable of a channel.
// Output stream (m_tvalid/m_tready/m_tdata) returns exactly one transaction per
// input event: the triac conduction mask and the zero-cross armed flag after it.
// The APB port holds step time, tick period and extra ticks at 0x0, 0x4, 0x8;
// write only while no event is in flight.
// A microcoded sequencer runs each event: fetch, work, emit. A tick, enable,
// disable or a zero crossing with no channel enabled goes from its work step to
// the emit step, which loads the output register behind m_tvalid, then to fetch.
// Otherwise a zero crossing walks every channel: multiply and advance for a
// skipped channel; multiply, the one-bit-per-cycle restoring divider over all
// 17 quotient bits, write and advance for an armed one; then the emit step.
// s_tready is high only while the sequencer waits at its fetch step. When the
// receiver stalls, the result holds in the output register; the next event can
// be accepted, and its own result waits at the emit step until the register drains.
// Reset clears all channel state, loads the register defaults (100, 30, 2) and
// leaves the output empty.
module triac_phase_dimmer #(
    parameter int CHANNELS = 5
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tpd_pkg::PADDR_W-1:0]       paddr,
    input  logic [tpd_pkg::PDATA_W-1:0]       pwdata,
    output logic [tpd_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action[1:0], channel[4:2], level[11:5], zero fill [15:12]
    input  logic [tpd_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // triac_on_mask[4:0], zero_cross_armed[5], zero fill [7:6]
    output logic [tpd_pkg::OUT_DATA_W-1:0]    m_tdata
);
    import tpd_pkg::*;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENCNT_W  = $clog2(CHANNELS + 1);

    logic [STEP_W-1:0]   step_time_reg;
    logic [PERIOD_W-1:0] tick_period_reg;
    logic [EXTRA_W-1:0]  extra_ticks_reg;

    upc_t   upc_reg, upc_next;
    uword_t uw;

    logic [CHAN_W-1:0]  item_ch_reg;
    logic [LEVEL_W-1:0] item_level_reg;

    logic [CHANNELS-1:0] chan_enabled_reg, chan_enabled_next;
    logic [CHANNELS-1:0] fire_pending_reg, fire_pending_next;
    logic [CHANNELS-1:0] triac_state_reg,  triac_state_next;
    logic [LEVEL_W-1:0]  chan_level_reg  [CHANNELS];
    logic [LEVEL_W-1:0]  chan_level_next [CHANNELS];
    logic [COUNT_W-1:0]  fire_count_reg  [CHANNELS];
    logic [COUNT_W-1:0]  fire_count_next [CHANNELS];
    logic [ENCNT_W-1:0]  en_count_reg, en_count_next;
    logic [CH_IDX_W-1:0] zc_idx_reg, zc_idx_next;

    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_armed_reg;
    logic [MASK_W-1:0]   mask_now;

    logic                in_accept;
    logic                out_free;
    logic                eligible;
    logic                chan_last;
    logic [LEVEL_W-1:0]  lvl_sat;
    logic [LEVEL_W-1:0]  zc_level;
    logic [PROD_W-1:0]   product;
    logic [PERIOD_W-1:0] divisor;
    logic [PROD_W-1:0]   quotient;
    logic                div_last;
    div_ctrl_t           div_ctrl;
    action_t             in_action;

    // configuration port
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_time_reg   <= STEP_RESET;
            tick_period_reg <= PERIOD_RESET;
            extra_ticks_reg <= EXTRA_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_STEP:   step_time_reg   <= pwdata[STEP_W-1:0];
                REG_PERIOD: tick_period_reg <= pwdata[PERIOD_W-1:0];
                REG_EXTRA:  extra_ticks_reg <= pwdata[EXTRA_W-1:0];
                REG_NONE:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_STEP:   prdata = PDATA_W'(step_time_reg);
            REG_PERIOD: prdata = PDATA_W'(tick_period_reg);
            REG_EXTRA:  prdata = PDATA_W'(extra_ticks_reg);
            REG_NONE:   prdata = '0;
        endcase
    end

    // sequencer
    assign uw        = ucode(upc_reg);
    assign s_tready  = upc_reg == UPC_FETCH;
    assign in_accept = s_tvalid && s_tready;
    assign in_action = action_t'(s_tdata[1:0]);
    assign out_free  = !out_valid_reg || m_tready;
    assign zc_level  = chan_level_reg[zc_idx_reg];
    assign eligible  = chan_enabled_reg[zc_idx_reg] && (zc_level != FULL_LEVEL);
    assign chan_last = zc_idx_reg == CH_IDX_W'(CHANNELS - 1);

    always_comb
    begin
        upc_next = upc_reg;
        unique case (uw.cond)
            C_NEXT:     upc_next = upc_reg + UPC_W'(1);
            C_JUMP:     upc_next = uw.target;
            C_DISPATCH:
            begin
                if (s_tvalid)
                begin
                    unique case (in_action)
                        ACT_TICK:    upc_next = UPC_TICK;
                        ACT_ZCROSS:  upc_next = UPC_ZCROSS;
                        ACT_ENABLE:  upc_next = UPC_ENABLE;
                        ACT_DISABLE: upc_next = UPC_DISABLE;
                    endcase
                end
            end
            C_ZERO_EN:  upc_next = (en_count_reg == '0) ? uw.target : upc_reg + UPC_W'(1);
            C_SKIP:     upc_next = eligible ? upc_reg + UPC_W'(1) : uw.target;
            C_DIV_LOOP: upc_next = div_last ? upc_reg + UPC_W'(1) : upc_reg;
            C_CH_LOOP:  upc_next = chan_last ? upc_reg + UPC_W'(1) : uw.target;
            C_WAIT_OUT: upc_next = out_free ? uw.target : upc_reg;
        endcase
    end

    // datapath
    assign lvl_sat  = (item_level_reg > FULL_LEVEL) ? FULL_LEVEL : item_level_reg;
    assign product  = PROD_W'(step_time_reg) * PROD_W'(zc_level);
    assign divisor  = (tick_period_reg == '0) ? PERIOD_W'(1) : tick_period_reg;
    assign div_ctrl = '{load: uw.op == OP_MUL, step: uw.op == OP_DIV};

    tpd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (product),
        .divisor  (divisor),
        .quotient (quotient),
        .last     (div_last)
    );

    always_comb
    begin
        logic hit;
        chan_enabled_next = chan_enabled_reg;
        fire_pending_next = fire_pending_reg;
        triac_state_next  = triac_state_reg;
        chan_level_next   = chan_level_reg;
        fire_count_next   = fire_count_reg;
        en_count_next     = en_count_reg;
        zc_idx_next       = zc_idx_reg;
        hit               = 1'b0;
        unique case (uw.op)
            OP_TICK:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (fire_pending_reg[c])
                    begin
                        if (fire_count_reg[c] <= COUNT_W'(1))
                        begin
                            fire_count_next[c]   = '0;
                            fire_pending_next[c] = 1'b0;
                            triac_state_next[c]  = 1'b1;
                        end
                        else
                        begin
                            fire_count_next[c] = fire_count_reg[c] - COUNT_W'(1);
                        end
                    end
                end
            end
            OP_ENABLE:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    hit = 32'(item_ch_reg) == c;
                    if (hit && !(chan_enabled_reg[c] && chan_level_reg[c] == lvl_sat))
                    begin
                        if (!chan_enabled_reg[c])
                        begin
                            chan_enabled_next[c] = 1'b1;
                            en_count_next        = en_count_reg + ENCNT_W'(1);
                        end
                        chan_level_next[c] = lvl_sat;
                        if (lvl_sat == FULL_LEVEL)
                        begin
                            triac_state_next[c]  = 1'b0;
                            fire_pending_next[c] = 1'b0;
                            fire_count_next[c]   = '0;
                        end
                    end
                end
            end
            OP_DISABLE:
            begin
                for (int c = 0; c < CHANNELS; c++)
                begin
                    hit = 32'(item_ch_reg) == c;
                    if (hit && chan_enabled_reg[c])
                    begin
                        chan_enabled_next[c] = 1'b0;
                        chan_level_next[c]   = '0;
                        triac_state_next[c]  = 1'b1;
                        fire_pending_next[c] = 1'b0;
                        fire_count_next[c]   = '0;
                        en_count_next        = en_count_reg - ENCNT_W'(1);
                    end
                end
            end
            OP_CH_CLR:  zc_idx_next = '0;
            OP_WRITE:
            begin
                triac_state_next[zc_idx_reg]  = 1'b0;
                fire_pending_next[zc_idx_reg] = 1'b1;
                fire_count_next[zc_idx_reg]   = COUNT_W'(quotient) + COUNT_W'(extra_ticks_reg);
            end
            OP_CH_INC:
            begin
                if (!chan_last)
                begin
                    zc_idx_next = zc_idx_reg + CH_IDX_W'(1);
                end
            end
            OP_NOP, OP_MUL, OP_DIV, OP_EMIT: ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg          <= UPC_FETCH;
            chan_enabled_reg <= '0;
            fire_pending_reg <= '0;
            triac_state_reg  <= '0;
            en_count_reg     <= '0;
            zc_idx_reg       <= '0;
            out_valid_reg    <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                chan_level_reg[c] <= '0;
                fire_count_reg[c] <= '0;
            end
        end
        else
        begin
            upc_reg          <= upc_next;
            chan_enabled_reg <= chan_enabled_next;
            fire_pending_reg <= fire_pending_next;
            triac_state_reg  <= triac_state_next;
            en_count_reg     <= en_count_next;
            zc_idx_reg       <= zc_idx_next;
            chan_level_reg   <= chan_level_next;
            fire_count_reg   <= fire_count_next;
            if (uw.op == OP_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_ch_reg    <= s_tdata[4:2];
            item_level_reg <= s_tdata[11:5];
        end
        if (uw.op == OP_EMIT && out_free)
        begin
            out_mask_reg  <= mask_now;
            out_armed_reg <= en_count_reg != '0;
        end
    end

    for (genvar b = 0; b < MASK_W; b++)
    begin : g_mask
        if (b < CHANNELS)
        begin : g_used
            assign mask_now[b] = triac_state_reg[b];
        end
        else
        begin : g_unused
            assign mask_now[b] = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - MASK_W - 1){1'b0}}, out_armed_reg, out_mask_reg};

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        32'(en_count_reg) == $countones(chan_enabled_reg))
        else $error("enabled count differs from enabled channels");

    a_pending_off: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_pending_reg & triac_state_reg) == '0)
        else $error("pending channel has triac on");

    a_pending_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        (fire_pending_reg & ~chan_enabled_reg) == '0)
        else $error("pending channel is not enabled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_tready)
        else $error("input accepted twice in a row");

endmodule

/* bench/tb_triac_phase_dimmer.sv */
module tb_triac_phase_dimmer;

    import tpd_pkg::*;

    localparam int CHANNELS    = 5;
    localparam int STALL_LIMIT = 3000;
    localparam int PHASE_ITEMS = 210;
    localparam int DRAIN_WAIT  = 120;

    typedef struct packed {
        logic               armed;
        logic [MASK_W-1:0]  mask;
    } dimmer_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [PDATA_W-1:0]    pwdata = '0;
    logic [PDATA_W-1:0]    prdata;
    logic                  pready;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic [IN_DATA_W-1:0]  event_q[$];
    dimmer_out_t           predicted_q[$];

    bit in_fire = 1'b0;
    bit calm = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;
    int quiet_cycles = 0;
    int mismatch_count = 0;

    // dimmer state as the block should hold it
    logic                 chan_on    [CHANNELS];
    logic [LEVEL_W-1:0]   chan_lvl   [CHANNELS];
    logic [COUNT_W-1:0]   chan_cnt   [CHANNELS];
    logic                 chan_armed [CHANNELS];
    logic                 triac_lit  [CHANNELS];
    int                   on_count;
    logic [STEP_W-1:0]    step_us;
    logic [PERIOD_W-1:0]  period_us;
    logic [EXTRA_W-1:0]   extra_tk;

    triac_phase_dimmer #(.CHANNELS(CHANNELS)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic clear_dimmer();
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_on[c]    = 1'b0;
            chan_lvl[c]   = '0;
            chan_cnt[c]   = '0;
            chan_armed[c] = 1'b0;
            triac_lit[c]  = 1'b0;
        end
        on_count  = 0;
        step_us   = STEP_RESET;
        period_us = PERIOD_RESET;
        extra_tk  = EXTRA_RESET;
    endtask

    task automatic apply_dimmer_event(input logic [IN_DATA_W-1:0] word,
                                      output dimmer_out_t res);
        action_t            act;
        logic [CHAN_W-1:0]  ch;
        logic [LEVEL_W-1:0] lvl;
        int unsigned        divisor;
        int unsigned        delay;
        int                 idx;
        act = action_t'(word[ACTION_W-1:0]);
        ch  = word[ACTION_W +: CHAN_W];
        lvl = word[ACTION_W+CHAN_W +: LEVEL_W];
        idx = int'(ch);
        case (act)
            ACT_TICK:
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (chan_armed[c])
                    begin
                        if (chan_cnt[c] <= 1)
                        begin
                            chan_cnt[c]   = '0;
                            chan_armed[c] = 1'b0;
                            triac_lit[c]  = 1'b1;
                        end
                        else
                        begin
                            chan_cnt[c] = chan_cnt[c] - 1'b1;
                        end
                    end
                end
            ACT_ZCROSS:
                if (on_count != 0)
                begin
                    divisor = (period_us == 0) ? 1 : 32'(period_us);
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (chan_on[c] && chan_lvl[c] != FULL_LEVEL)
                        begin
                            delay = (32'(step_us) * 32'(chan_lvl[c])) / divisor
                                    + 32'(extra_tk);
                            triac_lit[c]  = 1'b0;
                            chan_cnt[c]   = delay[COUNT_W-1:0];
                            chan_armed[c] = 1'b1;
                        end
                    end
                end
            ACT_ENABLE:
                if (idx < CHANNELS)
                begin
                    if (lvl > FULL_LEVEL)
                        lvl = FULL_LEVEL;
                    if (!(chan_on[idx] && chan_lvl[idx] == lvl))
                    begin
                        if (!chan_on[idx])
                        begin
                            chan_on[idx] = 1'b1;
                            on_count++;
                        end
                        chan_lvl[idx] = lvl;
                        if (lvl == FULL_LEVEL)
                        begin
                            triac_lit[idx]  = 1'b0;
                            chan_armed[idx] = 1'b0;
                            chan_cnt[idx]   = '0;
                        end
                    end
                end
            default:
                if (idx < CHANNELS && chan_on[idx])
                begin
                    chan_on[idx]    = 1'b0;
                    chan_lvl[idx]   = '0;
                    triac_lit[idx]  = 1'b1;
                    chan_armed[idx] = 1'b0;
                    chan_cnt[idx]   = '0;
                    on_count--;
                end
        endcase
        res.mask = '0;
        for (int c = 0; c < CHANNELS && c < MASK_W; c++)
            res.mask[c] = triac_lit[c];
        res.armed = (on_count != 0);
    endtask

    function automatic void post_event(action_t act, int ch, int lvl);
        event_q.push_back({4'b0000, LEVEL_W'(lvl), CHAN_W'(ch), act});
    endfunction

    function automatic int pick_channel();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
    endfunction

    function automatic int pick_level();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(101, 127) : $urandom_range(0, 100);
    endfunction

    // mostly half-cycles: a crossing and a run of ticks, with some noise mixed in
    task automatic queue_mains_traffic(input int count);
        int made;
        int roll;
        int run;
        made = 0;
        while (made < count)
        begin
            roll = $urandom_range(0, 19);
            if (roll == 0)
            begin
                post_event(action_t'($urandom_range(0, 3)), $urandom_range(0, 7),
                           $urandom_range(0, 127));
                made++;
            end
            else if (roll < 4)
            begin
                if ($urandom_range(0, 3) == 0)
                    post_event(ACT_DISABLE, pick_channel(), $urandom_range(0, 127));
                else
                    post_event(ACT_ENABLE, pick_channel(), pick_level());
                made++;
            end
            else
            begin
                post_event(ACT_ZCROSS, $urandom_range(0, 7), $urandom_range(0, 127));
                run = $urandom_range(0, 40);
                for (int i = 0; i < run; i++)
                    post_event(ACT_TICK, $urandom_range(0, 7), $urandom_range(0, 127));
                made += run + 1;
            end
        end
    endtask

    task automatic wait_drained();
        while (event_q.size() != 0 || s_tvalid || predicted_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
        logic [PDATA_W-1:0] rd;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd != val)
        begin
            $display("%0t: register %s expected %0d got %0d", $time, idx.name(), val, rd);
            mismatch_count++;
        end
        case (idx)
            REG_STEP:   step_us   = val[STEP_W-1:0];
            REG_PERIOD: period_us = val[PERIOD_W-1:0];
            REG_EXTRA:  extra_tk  = val[EXTRA_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic set_timing(input int step, input int period, input int extra);
        reg_write(REG_STEP, PDATA_W'(step));
        reg_write(REG_PERIOD, PDATA_W'(period));
        reg_write(REG_EXTRA, PDATA_W'(extra));
    endtask

    always @(negedge clk)
    begin
        logic                 nxt_valid;
        logic [IN_DATA_W-1:0] nxt_data;
        nxt_valid = s_tvalid;
        nxt_data  = s_tdata;
        if (!rst_n)
        begin
            nxt_valid = 1'b0;
        end
        else if (!s_tvalid || in_fire)
        begin
            nxt_valid = 1'b0;
            if (src_gap != 0)
                src_gap--;
            else if (!calm && $urandom_range(0, 9) == 0)
                src_gap = $urandom_range(0, 18);
            else if (event_q.size() != 0)
            begin
                nxt_valid = 1'b1;
                nxt_data  = event_q.pop_front();
            end
        end
        s_tvalid <= nxt_valid;
        s_tdata  <= nxt_data;

        if (sink_gap != 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            sink_gap = $urandom_range(0, 18);
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        dimmer_out_t got;
        dimmer_out_t want;
        bit          out_fire;
        in_fire  = rst_n && s_tvalid && s_tready;
        out_fire = rst_n && m_tvalid && m_tready;
        if (in_fire)
        begin
            apply_dimmer_event(s_tdata, want);
            predicted_q.push_back(want);
        end
        if (out_fire)
        begin
            got.mask  = m_tdata[MASK_W-1:0];
            got.armed = m_tdata[MASK_W];
            if (predicted_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none got mask %b armed %b",
                         $time, got.mask, got.armed);
                mismatch_count++;
            end
            else
            begin
                want = predicted_q.pop_front();
                if (got.mask !== want.mask)
                begin
                    $display("%0t: triac_on_mask expected %b got %b",
                             $time, want.mask, got.mask);
                    mismatch_count++;
                end
                if (got.armed !== want.armed)
                begin
                    $display("%0t: zero_cross_armed expected %b got %b",
                             $time, want.armed, got.armed);
                    mismatch_count++;
                end
            end
        end
        if (rst_n && !in_fire && !out_fire)
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("triac_phase_dimmer regression: fail");
            $finish;
        end
    end

    initial
    begin
        clear_dimmer();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default timing: 100 us steps, 30 us ticks, 2 extra ticks
        post_event(ACT_ZCROSS, 0, 0);
        post_event(ACT_TICK, 0, 0);
        post_event(ACT_DISABLE, 0, 0);
        post_event(ACT_ENABLE, 0, 0);
        post_event(ACT_ENABLE, 1, 127);
        post_event(ACT_ENABLE, 2, 50);
        post_event(ACT_ENABLE, 2, 50);
        post_event(ACT_ENABLE, 3, 100);
        post_event(ACT_ENABLE, 4, 1);
        post_event(ACT_ENABLE, 5, 10);
        post_event(ACT_ENABLE, 7, 127);
        post_event(ACT_DISABLE, 6, 0);
        post_event(ACT_ZCROSS, 7, 127);
        post_event(ACT_TICK, 0, 0);
        post_event(ACT_TICK, 7, 127);
        post_event(ACT_ZCROSS, 0, 0);
        post_event(ACT_ENABLE, 0, 100);
        post_event(ACT_DISABLE, 2, 0);
        for (int i = 0; i < 5; i++)
            post_event(ACT_TICK, i, 0);
        post_event(ACT_DISABLE, 3, 0);
        post_event(ACT_DISABLE, 1, 127);
        wait_drained();

        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        set_timing(1, 1023, 0);
        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        set_timing(1023, 1023, 15);
        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        // zero tick period counts as one
        set_timing(1, 0, 15);
        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        set_timing(1023, 1, 0);
        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        set_timing(10, 20, 3);
        calm = 1'b1;
        queue_mains_traffic(PHASE_ITEMS);
        wait_drained();

        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatch_count == 0 && predicted_q.size() == 0)
            $display("triac_phase_dimmer regression: pass");
        else
            $display("triac_phase_dimmer regression: fail");
        $finish;
    end

endmodule
